@@ src/iot_pkg.sv @@
// Package for the ITCH order tracker: widths, codes, state and command types.
// Used by iot_controller, iot_datapath and itch_order_tracker_unit; no dependencies.
package iot_pkg;

   localparam int TICKER_SLOTS = 64;
   localparam int ORDER_SLOTS  = 1048576;
   localparam int SLOT_W       = $clog2(ORDER_SLOTS);
   localparam int TIDX_W       = (TICKER_SLOTS > 1) ? $clog2(TICKER_SLOTS) : 1;
   localparam int COUNT_W      = $clog2(TICKER_SLOTS + 1);
   localparam int TICK_W       = 6;
   localparam int WORD_W       = 2 + TICK_W + 64;
   localparam int REQ_DATA_W   = 328;
   localparam int RSP_DATA_W   = 200;

   localparam logic [63:0] ALL_SPACES = 64'h2020_2020_2020_2020;

   localparam logic [2:0] ACT_ADD        = 3'd0;
   localparam logic [2:0] ACT_EXEC       = 3'd1;
   localparam logic [2:0] ACT_EXEC_PRICE = 3'd2;
   localparam logic [2:0] ACT_CANCEL     = 3'd3;
   localparam logic [2:0] ACT_DELETE     = 3'd4;
   localparam logic [2:0] ACT_REPLACE    = 3'd5;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_TRADE  = 2'd1;
   localparam logic [1:0] KIND_MODIFY = 2'd2;
   localparam logic [1:0] KIND_CANCEL = 2'd3;

   typedef enum logic [2:0] {
      EM_NONE, EM_ADD, EM_TRADE, EM_REDUCE, EM_DELETE, EM_RCANCEL, EM_RADD
   } emit_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_SRD, ST_SCMP, ST_ADD, ST_TRADE,
      ST_REDUCE, ST_DELETE, ST_RCANCEL, ST_RADD
   } state_type;

   typedef struct packed {
      logic     clear_step;
      logic     accept_ok;
      logic     search_start;
      logic     search_next;
      logic     set_found;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       blank;
      logic       valid;
      logic       count_zero;
      logic       match;
      logic       last_entry;
      logic       table_full;
      logic       out_free;
      logic       clear_done;
   } status_type;

endpackage

@@ src/iot_controller.sv @@
// Sequencer of the ITCH order tracker: clearing pass, lookup, symbol search, updates.
// Depends on iot_pkg; drives iot_datapath through command and status structs.
module iot_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  iot_pkg::status_type status,
   output iot_pkg::cmd_type    cmd
);

   iot_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iot_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iot_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = iot_pkg::ST_IDLE;
         end
         iot_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = iot_pkg::ST_LOOK;
         end
         iot_pkg::ST_LOOK: begin
            case (status.action)
               iot_pkg::ACT_ADD: begin
                  if (status.blank) state_in = iot_pkg::ST_IDLE;
                  else if (status.count_zero) state_in = iot_pkg::ST_ADD;
                  else state_in = iot_pkg::ST_SRD;
               end
               iot_pkg::ACT_EXEC, iot_pkg::ACT_EXEC_PRICE: begin
                  state_in = status.valid ? iot_pkg::ST_TRADE : iot_pkg::ST_IDLE;
               end
               iot_pkg::ACT_CANCEL: begin
                  state_in = status.valid ? iot_pkg::ST_REDUCE : iot_pkg::ST_IDLE;
               end
               iot_pkg::ACT_DELETE: begin
                  state_in = status.valid ? iot_pkg::ST_DELETE : iot_pkg::ST_IDLE;
               end
               iot_pkg::ACT_REPLACE: begin
                  state_in = status.valid ? iot_pkg::ST_RCANCEL : iot_pkg::ST_IDLE;
               end
               default: state_in = iot_pkg::ST_IDLE;
            endcase
         end
         iot_pkg::ST_SRD: state_in = iot_pkg::ST_SCMP;
         iot_pkg::ST_SCMP: begin
            if (status.match) state_in = iot_pkg::ST_ADD;
            else if (status.last_entry)
               state_in = status.table_full ? iot_pkg::ST_IDLE : iot_pkg::ST_ADD;
            else state_in = iot_pkg::ST_SRD;
         end
         iot_pkg::ST_ADD: begin
            if (status.out_free) state_in = iot_pkg::ST_IDLE;
         end
         iot_pkg::ST_TRADE: begin
            if (status.out_free) state_in = iot_pkg::ST_REDUCE;
         end
         iot_pkg::ST_REDUCE: begin
            if (status.out_free) state_in = iot_pkg::ST_IDLE;
         end
         iot_pkg::ST_DELETE: begin
            if (status.out_free) state_in = iot_pkg::ST_IDLE;
         end
         iot_pkg::ST_RCANCEL: begin
            if (status.out_free) state_in = iot_pkg::ST_RADD;
         end
         iot_pkg::ST_RADD: begin
            if (status.out_free) state_in = iot_pkg::ST_IDLE;
         end
         default: state_in = iot_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.emit = iot_pkg::EM_NONE;
      case (state_ff)
         iot_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         iot_pkg::ST_IDLE: cmd.accept_ok = 1'b1;
         iot_pkg::ST_LOOK: begin
            cmd.search_start = (status.action == iot_pkg::ACT_ADD) && !status.blank;
         end
         iot_pkg::ST_SCMP: begin
            cmd.set_found   = status.match;
            cmd.search_next = !status.match && !status.last_entry;
         end
         iot_pkg::ST_ADD: if (status.out_free) cmd.emit = iot_pkg::EM_ADD;
         iot_pkg::ST_TRADE: if (status.out_free) cmd.emit = iot_pkg::EM_TRADE;
         iot_pkg::ST_REDUCE: if (status.out_free) cmd.emit = iot_pkg::EM_REDUCE;
         iot_pkg::ST_DELETE: if (status.out_free) cmd.emit = iot_pkg::EM_DELETE;
         iot_pkg::ST_RCANCEL: if (status.out_free) cmd.emit = iot_pkg::EM_RCANCEL;
         iot_pkg::ST_RADD: if (status.out_free) cmd.emit = iot_pkg::EM_RADD;
         default: cmd.emit = iot_pkg::EM_NONE;
      endcase
   end

endmodule

@@ src/iot_datapath.sv @@
// Datapath of the ITCH order tracker: message register, order and symbol memories,
// ticker count, search index and the output register. Depends on iot_pkg.
module iot_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  iot_pkg::cmd_type               cmd,
   output iot_pkg::status_type            status,
   input  logic                           req_tvalid,
   input  logic [iot_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [iot_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast
);

   logic [2:0]  action_ff;
   logic [63:0] ref_ff, nref_ff, sym_ff;
   logic        buy_ff;
   logic [31:0] price_ff, shares_ff, delta_ff, xprice_ff;

   logic [iot_pkg::WORD_W-1:0] order_mem [iot_pkg::ORDER_SLOTS];
   logic [iot_pkg::WORD_W-1:0] word_ff;
   logic [63:0]                sym_mem [iot_pkg::TICKER_SLOTS];
   logic [63:0]                sym_rd_ff;

   logic [iot_pkg::SLOT_W-1:0]  clr_ff;
   logic [iot_pkg::COUNT_W-1:0] count_ff;
   logic [iot_pkg::TIDX_W-1:0]  idx_ff;
   logic                        found_ff;

   logic                        out_valid_ff;
   logic [iot_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic [1:0]                  out_kind_ff;
   logic                        out_last_ff;

   logic                        accept;
   logic                        we;
   logic [iot_pkg::SLOT_W-1:0]  waddr;
   logic [iot_pkg::WORD_W-1:0]  wdata;
   logic                        sym_we;
   logic [iot_pkg::COUNT_W-1:0] id_full;
   logic [iot_pkg::TICK_W-1:0]  add_tick, old_tick;
   logic                        old_buy;
   logic [31:0]                 old_qty, new_qty;
   logic [1:0]                  o_kind;
   logic [63:0]                 o_order, o_prio;
   logic [iot_pkg::TICK_W-1:0]  o_tick;
   logic                        o_buy, o_last;
   logic [31:0]                 o_price, o_qty;

   assign accept   = cmd.accept_ok && req_tvalid;
   assign old_tick = word_ff[63 + iot_pkg::TICK_W:64];
   assign old_buy  = word_ff[64 + iot_pkg::TICK_W];
   assign old_qty  = word_ff[31:0];
   assign new_qty  = (delta_ff >= old_qty) ? 32'd0 : old_qty - delta_ff;
   assign id_full  = found_ff ? iot_pkg::COUNT_W'(idx_ff) : count_ff;
   assign add_tick = iot_pkg::TICK_W'(id_full);
   assign sym_we   = (cmd.emit == iot_pkg::EM_ADD) && !found_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_tuser;
         ref_ff    <= req_tdata[63:0];
         nref_ff   <= req_tdata[127:64];
         sym_ff    <= req_tdata[191:128];
         buy_ff    <= req_tdata[192];
         price_ff  <= req_tdata[224:193];
         shares_ff <= req_tdata[256:225];
         delta_ff  <= req_tdata[288:257];
         xprice_ff <= req_tdata[320:289];
      end
   end

   always_comb begin
      we    = 1'b1;
      waddr = ref_ff[iot_pkg::SLOT_W-1:0];
      wdata = {1'b0, word_ff[iot_pkg::WORD_W-2:0]};
      case (cmd.emit)
         iot_pkg::EM_ADD: wdata = {1'b1, buy_ff, add_tick, price_ff, shares_ff};
         iot_pkg::EM_REDUCE: begin
            wdata = {(new_qty != 32'd0), word_ff[iot_pkg::WORD_W-2:32], new_qty};
         end
         iot_pkg::EM_DELETE, iot_pkg::EM_RCANCEL: wdata = {1'b0, word_ff[iot_pkg::WORD_W-2:0]};
         iot_pkg::EM_RADD: begin
            waddr = nref_ff[iot_pkg::SLOT_W-1:0];
            wdata = {1'b1, old_buy, old_tick, price_ff, shares_ff};
         end
         default: begin
            we    = cmd.clear_step;
            waddr = clr_ff;
            wdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) order_mem[waddr] <= wdata;
      if (accept) word_ff <= order_mem[req_tdata[iot_pkg::SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[iot_pkg::TIDX_W'(count_ff)] <= sym_ff;
      sym_rd_ff <= sym_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (sym_we) count_ff <= count_ff + 1'b1;
         if (cmd.search_start) idx_ff <= '0;
         else if (cmd.search_next) idx_ff <= idx_ff + 1'b1;
         if (accept) found_ff <= 1'b0;
         else if (cmd.set_found) found_ff <= 1'b1;
         if (cmd.emit != iot_pkg::EM_NONE) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      o_kind  = iot_pkg::KIND_CANCEL;
      o_order = ref_ff;
      o_tick  = old_tick;
      o_buy   = 1'b0;
      o_price = 32'd0;
      o_qty   = 32'd0;
      o_prio  = 64'd0;
      o_last  = 1'b1;
      case (cmd.emit)
         iot_pkg::EM_ADD: begin
            o_kind  = iot_pkg::KIND_ADD;
            o_tick  = add_tick;
            o_buy   = buy_ff;
            o_price = price_ff;
            o_qty   = shares_ff;
            o_prio  = ref_ff;
         end
         iot_pkg::EM_TRADE: begin
            o_kind  = iot_pkg::KIND_TRADE;
            o_buy   = old_buy;
            o_price = (action_ff == iot_pkg::ACT_EXEC_PRICE) ? xprice_ff : word_ff[63:32];
            o_qty   = delta_ff;
            o_last  = 1'b0;
         end
         iot_pkg::EM_REDUCE: begin
            o_kind = (new_qty == 32'd0) ? iot_pkg::KIND_CANCEL : iot_pkg::KIND_MODIFY;
            o_qty  = new_qty;
         end
         iot_pkg::EM_RCANCEL: o_last = 1'b0;
         iot_pkg::EM_RADD: begin
            o_kind  = iot_pkg::KIND_ADD;
            o_order = nref_ff;
            o_buy   = old_buy;
            o_price = price_ff;
            o_qty   = shares_ff;
            o_prio  = nref_ff;
         end
         default: o_last = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != iot_pkg::EM_NONE) begin
         out_data_ff <= {1'b0, o_prio, o_qty, o_price, o_buy, o_tick, o_order};
         out_kind_ff <= o_kind;
         out_last_ff <= o_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.action     = action_ff;
   assign status.blank      = (sym_ff == iot_pkg::ALL_SPACES);
   assign status.valid      = word_ff[iot_pkg::WORD_W-1];
   assign status.count_zero = (count_ff == '0);
   assign status.match      = (sym_rd_ff == sym_ff);
   assign status.last_entry = ((iot_pkg::COUNT_W'(idx_ff) + 1'b1) == count_ff);
   assign status.table_full = (count_ff >= iot_pkg::COUNT_W'(iot_pkg::TICKER_SLOTS));
   assign status.out_free   = !out_valid_ff || rsp_tready;
   assign status.clear_done = (clr_ff == iot_pkg::SLOT_W'(iot_pkg::ORDER_SLOTS - 1));

endmodule

@@ src/itch_order_tracker_unit.sv @@
// Top level of the ITCH order tracker: controller plus datapath and a few assertions.
// Depends on iot_pkg, iot_controller and iot_datapath.
//
// The req_ channel carries one decoded message per transfer, with the action code in
// req_tuser. The rsp_ channel carries book updates, the update kind in rsp_tuser and
// rsp_tlast set on the last update of a message. A message gives zero, one or two updates.
// Messages are handled one at a time. A message first reads its order table entry,
// then gives its updates one after another. An add also searches the symbol table,
// reading and then comparing one known symbol after another. The order table
// read-modify-write and the serial symbol search set the message timing.
// After reset the block clears the valid bits of all ORDER_SLOTS (1048576) entries of
// the order table, one entry per cycle; req_tready stays low during that pass.
// Updates wait in an output register; while the receiver stalls, the block holds at the
// next update and takes no new message until its last update is in the output register.
module itch_order_tracker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // order_ref, new_order_ref, stock_symbol, is_buy, order_price, order_shares,
   // delta_shares, exec_price; zero padding above
   input  logic [iot_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [2:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // update_order, update_ticker, update_buy, update_price, update_qty,
   // update_priority; zero padding above
   output logic [iot_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // update_kind
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast
);

   iot_pkg::cmd_type    cmd;
   iot_pkg::status_type status;

   iot_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   iot_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = cmd.accept_ok;

   a_clear_after_reset: assert property (@(posedge clock) $past(reset) |-> !req_tready)
      else $error("ready raised during the clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second message accepted while one is in progress");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != iot_pkg::EM_NONE) |-> status.out_free)
      else $error("update loaded while the output register is occupied");

endmodule
